>>> rtl/core/rssa_pkg.sv
// ============================================================================
// Rectangle set package
// Shared types and constants of the rectangle set keeper.
// ============================================================================
`default_nettype none
package rssa_pkg;
    localparam int MaxRects  = 64;
    localparam int CoordBits = 16;
    localparam int IdxBits   = $clog2(MaxRects);
    localparam int CntBits   = IdxBits + 1;
    localparam int AreaBits  = 40;

    typedef enum logic [1:0] {
        FUNC_SUB  = 2'd0,
        FUNC_ADD  = 2'd1,
        FUNC_SUM  = 2'd2,
        FUNC_LIST = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [CoordBits-1:0] t;
        logic signed [CoordBits-1:0] b;
        logic signed [CoordBits-1:0] l;
        logic signed [CoordBits-1:0] r;
    } t_box;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CUT, S_PIECE, S_APPEND, S_SWAP,
        S_SUM, S_SUM_END, S_LIST, S_RESP, S_WAIT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_cmd;    // capture input request
        logic clr_idx;     // restart walk
        logic rd;          // read current entry
        logic cut_load;    // capture entry into cut working set
        logic piece;       // emit next piece or whole entry
        logic append;      // push request rectangle
        logic swap;        // toggle banks and commit count
        logic sum_init;
        logic sum_acc;
        logic out_resp;    // single response
        logic out_list;    // list entry response
        logic out_sum;     // summary response
        logic next_idx;
    } t_cmd;

    typedef struct packed {
        logic idx_last;    // current index is last stored entry
        logic empty;       // stored count is zero
        logic cut_done;    // nothing left to emit for this entry
        logic out_busy;    // output register holds a result the receiver is not taking
    } t_stat;
endpackage
`default_nettype wire

>>> rtl/core/rssa_ctrl.sv
// ============================================================================
// Rectangle set controller
// Sequences reads, cuts, summaries and listing over the stored set.
// ============================================================================
`default_nettype none
module rssa_ctrl
    import rssa_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req,
    input  wire t_func i_func,
    input  wire t_stat i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;
    t_func  r_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= FUNC_SUB;
        end else begin
            r_state <= n_state;
            if (i_req) r_func <= i_func;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req) begin
                    if (i_stat.empty) begin
                        if (i_func == FUNC_ADD) n_state = S_APPEND;
                        else if (i_func == FUNC_SUB) n_state = S_SWAP;
                        else n_state = S_RESP;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                if (r_func == FUNC_SUM) n_state = S_SUM;
                else if (r_func == FUNC_LIST) n_state = S_LIST;
                else n_state = S_CUT;
            end
            S_CUT:   n_state = S_PIECE;
            S_PIECE: begin
                if (i_stat.cut_done) begin
                    if (!i_stat.idx_last) n_state = S_RD;
                    else if (r_func == FUNC_ADD) n_state = S_APPEND;
                    else n_state = S_SWAP;
                end
            end
            S_APPEND: n_state = S_SWAP;
            S_SWAP:   n_state = S_RESP;
            S_SUM:    n_state = i_stat.idx_last ? S_SUM_END : S_RD;
            S_SUM_END: if (!i_stat.out_busy) n_state = S_WAIT;
            S_LIST: begin
                if (!i_stat.out_busy) n_state = i_stat.idx_last ? S_WAIT : S_RD;
            end
            S_RESP:   if (!i_stat.out_busy) n_state = S_WAIT;
            S_WAIT:   if (!i_stat.out_busy) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        o_cmd.load_cmd = i_req;
        o_cmd.clr_idx  = i_req;
        unique case (r_state)
            S_RD:     begin
                o_cmd.rd = 1'b1;
                if (r_func == FUNC_SUM) o_cmd.sum_init = 1'b0;
            end
            S_CUT:    o_cmd.cut_load = 1'b1;
            S_PIECE:  begin
                o_cmd.piece = 1'b1;
                if (i_stat.cut_done) o_cmd.next_idx = 1'b1;
            end
            S_APPEND: o_cmd.append = 1'b1;
            S_SWAP:   o_cmd.swap = 1'b1;
            S_SUM:    begin
                o_cmd.sum_acc  = 1'b1;
                o_cmd.next_idx = 1'b1;
            end
            S_SUM_END: o_cmd.out_sum = !i_stat.out_busy;
            S_LIST:   begin
                o_cmd.out_list = !i_stat.out_busy;
                o_cmd.next_idx = !i_stat.out_busy;
            end
            S_RESP:   o_cmd.out_resp = !i_stat.out_busy;
            default:  ;
        endcase
        if (r_state == S_IDLE && i_req) o_cmd.sum_init = 1'b1;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.out_resp, o_cmd.out_list, o_cmd.out_sum}) <= 1)
        else $error("two results at once");
    a_swap_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.swap |=> r_state == S_RESP) else $error("swap not followed by response");
endmodule
`default_nettype wire

>>> rtl/core/rssa_dp.sv
// ============================================================================
// Rectangle set datapath
// Two entry banks, cut logic, area accumulator and the output register.
// ============================================================================
`default_nettype none
module rssa_dp
    import rssa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire t_box                 i_box,
    input  wire logic                 i_out_ready,
    output t_stat                     o_stat,
    output logic                      o_out_valid,
    output t_box                      o_out_box,
    output logic [AreaBits-1:0]       o_out_area,
    output logic [CntBits-1:0]        o_out_count,
    output logic                      o_out_ovf,
    output logic                      o_out_entry_valid,
    output logic                      o_out_last
);
    localparam logic [AreaBits-1:0] AreaMax = '1;

    t_box r_bank_a [MaxRects];
    t_box r_bank_b [MaxRects];
    logic r_active;
    logic [CntBits-1:0] r_count, r_wcnt;
    logic r_ovf;
    logic [IdxBits-1:0] r_idx;
    t_box r_c, r_rd, r_w;
    logic r_hit;
    logic [3:0] r_pend;
    t_box r_enc;
    logic [AreaBits-1:0] r_area;
    logic [2*CoordBits+1:0] n_prod;
    logic [CoordBits:0] n_h, n_w;

    // Write port: one piece per cycle into the inactive bank. An appended
    // rectangle goes there too, since that bank becomes the current one.
    logic n_we, n_we_cur;
    t_box n_wbox;
    logic n_last_piece;

    always_comb begin
        n_we = 1'b0; n_wbox = r_w; n_last_piece = 1'b1;
        if (i_cmd.piece) begin
            if (!r_hit) begin
                n_we = 1'b1; n_wbox = r_w;
            end else if (r_pend[0]) begin
                n_we = 1'b1; n_wbox = '{t: r_w.t, b: r_c.t, l: r_w.l, r: r_w.r};
                n_last_piece = (r_pend[3:1] == 3'b0);
            end else if (r_pend[1]) begin
                n_we = 1'b1; n_wbox = '{t: r_w.t, b: r_w.b, l: r_w.l, r: r_c.l};
                n_last_piece = (r_pend[3:2] == 2'b0);
            end else if (r_pend[2]) begin
                n_we = 1'b1; n_wbox = '{t: r_c.b, b: r_w.b, l: r_w.l, r: r_w.r};
                n_last_piece = !r_pend[3];
            end else if (r_pend[3]) begin
                n_we = 1'b1; n_wbox = '{t: r_w.t, b: r_w.b, l: r_c.r, r: r_w.r};
            end
        end
        n_we_cur = i_cmd.append;
        if (n_we_cur) n_wbox = r_c;
    end

    logic n_room;
    assign n_room = (r_wcnt < CntBits'(MaxRects));

    always_ff @(posedge i_clk) begin
        if ((n_we || n_we_cur) && n_room) begin
            if (r_active) r_bank_a[r_wcnt[IdxBits-1:0]] <= n_wbox;
            else r_bank_b[r_wcnt[IdxBits-1:0]] <= n_wbox;
        end
        if (i_cmd.rd) r_rd <= r_active ? r_bank_b[r_idx] : r_bank_a[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_wcnt   <= '0;
            r_idx    <= '0;
            r_pend   <= '0;
        end else begin
            if (i_cmd.clr_idx) begin
                r_idx  <= '0;
                r_wcnt <= '0;
            end
            if (i_cmd.next_idx) r_idx <= r_idx + 1'b1;
            if (i_cmd.append) begin
                if (n_room) r_wcnt <= r_wcnt + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (i_cmd.cut_load) begin
                r_pend <= {r_rd.r > r_c.r, r_rd.b > r_c.b, r_rd.l < r_c.l,
                           r_rd.t < r_c.t};
            end else if (i_cmd.piece && n_we) begin
                if (n_room) r_wcnt <= r_wcnt + 1'b1;
                else r_ovf <= 1'b1;
                if (r_hit) begin
                    if (r_pend[0]) r_pend[0] <= 1'b0;
                    else if (r_pend[1]) r_pend[1] <= 1'b0;
                    else if (r_pend[2]) r_pend[2] <= 1'b0;
                    else r_pend[3] <= 1'b0;
                end
            end
            if (i_cmd.swap) begin
                r_active <= !r_active;
                r_count  <= r_wcnt;
            end
        end
    end

    // Working entry and hit flag, narrowed by each emitted piece.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) r_c <= i_box;
        if (i_cmd.cut_load) begin
            r_w   <= r_rd;
            r_hit <= !(r_rd.t > r_c.b || r_rd.b < r_c.t || r_rd.l > r_c.r || r_rd.r < r_c.l);
        end else if (i_cmd.piece && r_hit) begin
            if (r_pend[0]) r_w.t <= r_c.t;
            else if (r_pend[1]) r_w.l <= r_c.l;
            else if (r_pend[2]) r_w.b <= r_c.b;
        end
    end

    // Area and enclosing box, accumulated over the entries as they are read.
    always_comb begin
        n_h = (r_rd.b > r_rd.t) ? (CoordBits+1)'(r_rd.b - r_rd.t) : '0;
        n_w = (r_rd.r > r_rd.l) ? (CoordBits+1)'(r_rd.r - r_rd.l) : '0;
        n_prod = n_h * n_w;
    end

    logic [AreaBits:0] n_sum;
    assign n_sum = {1'b0, r_area} + (AreaBits+1)'(n_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_area <= '0;
            r_enc  <= r_active ? r_bank_b[0] : r_bank_a[0];
        end else if (i_cmd.sum_acc) begin
            r_area <= n_sum[AreaBits] ? AreaMax : n_sum[AreaBits-1:0];
            if (r_rd.t < r_enc.t) r_enc.t <= r_rd.t;
            if (r_rd.b > r_enc.b) r_enc.b <= r_rd.b;
            if (r_rd.l < r_enc.l) r_enc.l <= r_rd.l;
            if (r_rd.r > r_enc.r) r_enc.r <= r_rd.r;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_resp || i_cmd.out_list || i_cmd.out_sum) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_resp || i_cmd.out_list || i_cmd.out_sum) begin
            o_out_box         <= i_cmd.out_list ? r_rd : (i_cmd.out_sum ? r_enc : '0);
            o_out_area        <= i_cmd.out_sum ? r_area : '0;
            o_out_count       <= r_count;
            o_out_ovf         <= r_ovf;
            o_out_entry_valid <= i_cmd.out_list || i_cmd.out_sum;
            o_out_last        <= i_cmd.out_list ? o_stat.idx_last : 1'b1;
        end
    end

    always_comb begin
        o_stat.idx_last = (CntBits'(r_idx) + 1'b1 == r_count);
        o_stat.empty    = (r_count == '0);
        o_stat.cut_done = !r_hit || n_last_piece;
        o_stat.out_busy = o_out_valid && !i_out_ready;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(MaxRects)) else $error("count above capacity");
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ovf) |-> r_ovf) else $error("overflow flag cleared");
    a_wcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= CntBits'(MaxRects)) else $error("fill above capacity");
endmodule
`default_nettype wire

>>> rtl/core/rectangle_set_subtract_add.sv
// ============================================================================
// Rectangle set keeper
// Holds a bounded region of rectangles; subtract, add, summary and list.
// ============================================================================
// Usage: a request enters on the s_axis group. s_axis_tuser carries the
// operation (0 subtract, 1 add, 2 summary, 3 list) and s_axis_tdata the
// rectangle. Results leave on m_axis; m_axis_tlast marks the last result of
// a request. Subtract and add give one result; list gives one per entry.
// Subtract and add walk every stored entry and write up to four pieces into
// the spare bank, one piece per cycle: each entry passes a read step, a cut
// step and one piece step per piece written (at least one, even when nothing
// of the entry survives). Add then appends the rectangle, and both then swap
// banks and load the result into the output register. Summary reads and
// accumulates each entry in turn and then loads one result; list reads each
// entry and loads it as a result, waiting while the receiver stalls. The
// block takes one request at a time; s_axis_tready is high only between
// requests. Reset clears the entry count, the active bank and the overflow
// flag; the banks themselves are not cleared. When the receiver stalls, the
// result holds in the output register and the walk waits.
// ============================================================================
`default_nettype none
module rectangle_set_subtract_add
    import rssa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: in_top, in_bottom, in_left, in_right
    input  wire logic [63:0] s_axis_tdata,
    // tuser: func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_top, out_bottom, out_left, out_right, total_area,
    //        entry_count, overflow, entry_valid (zero padded to 120 bits)
    output logic [119:0]     m_axis_tdata,
    output logic             m_axis_tlast
);
    t_cmd  w_cmd;
    t_stat w_stat;
    t_box  w_in_box, w_out_box;
    logic  w_req;
    logic [AreaBits-1:0] w_area;
    logic [CntBits-1:0]  w_cnt;
    logic  w_ovf, w_ev;

    assign w_req = s_axis_tvalid && s_axis_tready;
    assign w_in_box = '{t: s_axis_tdata[15:0], b: s_axis_tdata[31:16],
                        l: s_axis_tdata[47:32], r: s_axis_tdata[63:48]};

    rssa_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_req(w_req), .i_func(t_func'(s_axis_tuser)),
        .i_stat(w_stat), .o_ready(s_axis_tready), .o_cmd(w_cmd)
    );

    rssa_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_box(w_in_box),
        .i_out_ready(m_axis_tready), .o_stat(w_stat), .o_out_valid(m_axis_tvalid),
        .o_out_box(w_out_box), .o_out_area(w_area), .o_out_count(w_cnt),
        .o_out_ovf(w_ovf), .o_out_entry_valid(w_ev), .o_out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, w_ev, w_ovf, w_cnt, w_area,
                           w_out_box.r, w_out_box.l, w_out_box.b, w_out_box.t};
endmodule
`default_nettype wire
